@@ sv/sprite_register_bank_core_macros.svh @@
// ---------------------------------------------------------------------------
// Sprite register bank assertion macros
// Concurrent assertion helpers shared by the sprite register bank modules.
// ---------------------------------------------------------------------------
`ifndef SPRITE_REGISTER_BANK_CORE_MACROS_SVH
`define SPRITE_REGISTER_BANK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SRB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite register bank: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite register bank: assertion failed");
`else
`define SRB_ASSERT_SAME(label, clk, rst, ante, cons)
`define SRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/srb_pkg.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank package
// Sizes, register offsets, controller interface types and byte lane helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srb_pkg;

   localparam int NUM_SPRITES       = 32;
   localparam int PALETTE_ENTRIES   = 256;
   localparam int PIXELS_PER_SPRITE = 256;

   localparam int SPR_W      = $clog2(NUM_SPRITES);
   localparam int PAL_W      = $clog2(PALETTE_ENTRIES);
   localparam int PIX_DEPTH  = NUM_SPRITES * PIXELS_PER_SPRITE;
   localparam int PIX_ADDR_W = $clog2(PIX_DEPTH);

   // The clearing pass sweeps both memories together.
   localparam int CLEAR_DEPTH = (PIX_DEPTH > PALETTE_ENTRIES) ? PIX_DEPTH : PALETTE_ENTRIES;
   localparam int CLR_W       = $clog2(CLEAR_DEPTH);

   localparam logic [4:0] OFS_ENABLE_FIRST  = 5'd0;
   localparam logic [4:0] OFS_ENABLE_LAST   = 5'd3;
   localparam logic [4:0] OFS_COL_ENA_FIRST = 5'd4;
   localparam logic [4:0] OFS_COL_ENA_LAST  = 5'd7;
   localparam logic [4:0] OFS_COL_TYP_FIRST = 5'd8;
   localparam logic [4:0] OFS_COL_TYP_LAST  = 5'd11;
   localparam logic [4:0] OFS_PAL_IDX       = 5'd12;
   localparam logic [4:0] OFS_PAL_DATA_HI   = 5'd13;
   localparam logic [4:0] OFS_PAL_DATA_LO   = 5'd14;
   localparam logic [4:0] OFS_SPR_IDX       = 5'd15;
   localparam logic [4:0] OFS_COL_DET_FIRST = 5'd16;
   localparam logic [4:0] OFS_COL_DET_LAST  = 5'd19;
   localparam logic [4:0] OFS_H_POS_HI      = 5'd20;
   localparam logic [4:0] OFS_H_POS_LO      = 5'd21;
   localparam logic [4:0] OFS_V_POS_HI      = 5'd22;
   localparam logic [4:0] OFS_V_POS_LO      = 5'd23;
   localparam logic [4:0] OFS_X_OFS         = 5'd24;
   localparam logic [4:0] OFS_Y_OFS         = 5'd25;
   localparam logic [4:0] OFS_PRIO          = 5'd26;
   localparam logic [4:0] OFS_BMP_IDX       = 5'd27;
   localparam logic [4:0] OFS_BMP_DATA      = 5'd28;

   typedef struct packed {
      logic capture;
      logic exec;
      logic clear;
   } srb_cmd_type;

   typedef struct packed {
      logic clear_last;
   } srb_status_type;

   // Big-endian byte lanes: lane 0 is the most significant byte.
   function automatic logic [7:0] get32(input logic [31:0] w, input logic [1:0] lane);
      logic [7:0] b;
      case (lane)
         2'd0:    b = w[31:24];
         2'd1:    b = w[23:16];
         2'd2:    b = w[15:8];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [31:0] put32(input logic [31:0] w, input logic [1:0] lane,
                                         input logic [7:0] d);
      logic [31:0] r;
      r = w;
      case (lane)
         2'd0:    r[31:24] = d;
         2'd1:    r[23:16] = d;
         2'd2:    r[15:8]  = d;
         default: r[7:0]   = d;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] get16(input logic [15:0] w, input logic lane);
      return lane ? w[7:0] : w[15:8];
   endfunction

   function automatic logic [15:0] put16(input logic [15:0] w, input logic lane,
                                         input logic [7:0] d);
      return lane ? {w[15:8], d} : {d, w[7:0]};
   endfunction

   // Remainder of a byte by a fixed modulus through restoring subtraction steps.
   function automatic logic [7:0] mod_reduce(input logic [7:0] v, input int unsigned m);
      logic [15:0] r;
      r = {8'd0, v};
      for (int k = 7; k >= 0; k--) begin
         if ({16'd0, r} >= 32'(m << k)) begin
            r = 16'(32'(r) - 32'(m << k));
         end
      end
      return r[7:0];
   endfunction

endpackage

@@ sv/sprite_register_bank_core.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank core
// Byte-wide bus register bank of a sprite display unit with stream ports.
// ---------------------------------------------------------------------------
// Each request transaction reads or writes one byte at a register offset and
// produces exactly one response byte: the byte read, or the written byte
// echoed back (unmapped offsets 29 to 31 always echo the request byte). A
// transaction has a capture step and an execute step, because the palette and
// pixel memories have a registered read port that is read in the capture
// cycle and written back in the execute cycle; so a new request is not accepted
// until the previous one has executed, and a request may be accepted while the
// previous response is being taken. After reset a clearing pass zeroes both
// memories, one entry per cycle, for the larger of the pixel store depth and
// the palette depth (8192 entries with the default sizes), with req_tready low.
`timescale 1ns / 1ps

module sprite_register_bank_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // reg_offset[4:0], wr_data[12:5], zero[15:13]
   input  logic [0:0]  req_tuser,  // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // rd_data[7:0]
);

   srb_pkg::srb_cmd_type    cmd;
   srb_pkg::srb_status_type status;

   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   srb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_type  (req_tuser[0]),
      .reg_offset(req_tdata[4:0]),
      .wr_data   (req_tdata[12:5]),
      .rd_data   (rsp_tdata)
   );

endmodule

@@ sv/srb_ram.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank RAM
// Generic simple dual port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/srb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank controller
// Sequences the clearing pass, transaction capture, execution and response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_register_bank_core_macros.svh"

module srb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  srb_pkg::srb_status_type status,
   output srb_pkg::srb_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // A new transaction may enter while the previous response is being taken.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.capture = accept;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.clear   = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (state_ff == ST_EXEC) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `SRB_ASSERT_SAME(a_no_accept_over_held_rsp, clock, reset, accept, !rsp_valid_ff || rsp_tready)
   `SRB_ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC)
   `SRB_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, state_ff == ST_EXEC, rsp_valid_ff)
   `SRB_ASSERT_SAME(a_exec_with_empty_rsp, clock, reset, state_ff == ST_EXEC, !rsp_valid_ff)
   `SRB_ASSERT_SAME(a_closed_during_clear, clock, reset, state_ff == ST_CLEAR, !req_tready)

endmodule

@@ sv/srb_datapath.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank datapath
// Register file, palette and pixel memories, address decode and read mux.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  srb_pkg::srb_cmd_type    cmd,
   output srb_pkg::srb_status_type status,
   input  logic                   req_type,
   input  logic [4:0]             reg_offset,
   input  logic [7:0]             wr_data,
   output logic [7:0]             rd_data
);

   // Captured transaction.
   logic       req_wr_ff;
   logic [4:0] req_ofs_ff;
   logic [7:0] req_data_ff;

   logic [7:0] rsp_data_ff;
   logic [7:0] rsp_data_in;

   logic [srb_pkg::CLR_W-1:0] clr_cnt_ff;

   // Global registers.
   logic [31:0]              enable_ff, enable_in;
   logic [31:0]              col_ena_ff, col_ena_in;
   logic [31:0]              col_typ_ff, col_typ_in;
   logic [7:0]               pal_ptr_ff, pal_ptr_in;
   logic [srb_pkg::SPR_W-1:0] cur_ff, cur_in;

   // Per-sprite registers, written only at the selected sprite.
   logic [31:0] col_det_ff  [srb_pkg::NUM_SPRITES];
   logic [15:0] h_pos_ff    [srb_pkg::NUM_SPRITES];
   logic [15:0] v_pos_ff    [srb_pkg::NUM_SPRITES];
   logic [7:0]  x_ofs_ff    [srb_pkg::NUM_SPRITES];
   logic [7:0]  y_ofs_ff    [srb_pkg::NUM_SPRITES];
   logic [7:0]  prio_ff     [srb_pkg::NUM_SPRITES];
   logic [7:0]  bmp_idx_ff  [srb_pkg::NUM_SPRITES];
   logic [31:0] col_det_in;
   logic [15:0] h_pos_in, v_pos_in;
   logic [7:0]  byte_in;
   logic        col_det_we, h_pos_we, v_pos_we, x_ofs_we, y_ofs_we, prio_we, bmp_idx_we;

   logic                          wr;
   logic [srb_pkg::PAL_W-1:0]      pal_addr;
   logic [srb_pkg::PIX_ADDR_W-1:0] pix_addr;
   logic [7:0]                    bmp_px;
   logic [15:0]                   pal_rdata, pal_wdata, pal_mod_data;
   logic [7:0]                    pix_rdata, pix_wdata;
   logic                          pal_we, pix_we, pal_mod_we, pix_mod_we;
   logic                          pal_clr_we, pix_clr_we;
   logic [srb_pkg::PAL_W-1:0]      pal_wr_addr;
   logic [srb_pkg::PIX_ADDR_W-1:0] pix_wr_addr;

   assign wr = cmd.exec && req_wr_ff;

   // Memory addresses follow the registers, which do not change between
   // capture (read issued) and execution (read data used, write done).
   assign pal_addr = srb_pkg::PAL_W'(srb_pkg::mod_reduce(pal_ptr_ff,
                                                         srb_pkg::PALETTE_ENTRIES));
   assign bmp_px   = srb_pkg::mod_reduce(bmp_idx_ff[cur_ff], srb_pkg::PIXELS_PER_SPRITE);
   assign pix_addr = srb_pkg::PIX_ADDR_W'(int'(cur_ff) * srb_pkg::PIXELS_PER_SPRITE
                                          + int'(bmp_px));

   assign status.clear_last = (clr_cnt_ff == srb_pkg::CLR_W'(srb_pkg::CLEAR_DEPTH - 1));

   always_comb begin
      rsp_data_in  = req_data_ff;
      enable_in    = enable_ff;
      col_ena_in   = col_ena_ff;
      col_typ_in   = col_typ_ff;
      pal_ptr_in   = pal_ptr_ff;
      cur_in       = cur_ff;
      col_det_in   = col_det_ff[cur_ff];
      h_pos_in     = h_pos_ff[cur_ff];
      v_pos_in     = v_pos_ff[cur_ff];
      byte_in      = req_data_ff;
      pal_mod_data = pal_rdata;
      col_det_we   = 1'b0;
      h_pos_we     = 1'b0;
      v_pos_we     = 1'b0;
      x_ofs_we     = 1'b0;
      y_ofs_we     = 1'b0;
      prio_we      = 1'b0;
      bmp_idx_we   = 1'b0;
      pal_mod_we   = 1'b0;
      pix_mod_we   = 1'b0;

      // The 32-bit words start on multiples of four, so the lane is the
      // low two offset bits. Writes echo the written byte.
      case (req_ofs_ff) inside
         [srb_pkg::OFS_ENABLE_FIRST:srb_pkg::OFS_ENABLE_LAST]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get32(enable_ff, req_ofs_ff[1:0]);
            enable_in = srb_pkg::put32(enable_ff, req_ofs_ff[1:0], req_data_ff);
         end
         [srb_pkg::OFS_COL_ENA_FIRST:srb_pkg::OFS_COL_ENA_LAST]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get32(col_ena_ff, req_ofs_ff[1:0]);
            col_ena_in = srb_pkg::put32(col_ena_ff, req_ofs_ff[1:0], req_data_ff);
         end
         [srb_pkg::OFS_COL_TYP_FIRST:srb_pkg::OFS_COL_TYP_LAST]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get32(col_typ_ff, req_ofs_ff[1:0]);
            col_typ_in = srb_pkg::put32(col_typ_ff, req_ofs_ff[1:0], req_data_ff);
         end
         srb_pkg::OFS_PAL_IDX: begin
            if (!req_wr_ff) rsp_data_in = pal_ptr_ff;
            pal_ptr_in = req_data_ff;
         end
         [srb_pkg::OFS_PAL_DATA_HI:srb_pkg::OFS_PAL_DATA_LO]: begin
            // The high byte sits at the odd offset here.
            if (!req_wr_ff) rsp_data_in = srb_pkg::get16(pal_rdata, ~req_ofs_ff[0]);
            pal_mod_data = srb_pkg::put16(pal_rdata, ~req_ofs_ff[0], req_data_ff);
            pal_mod_we   = 1'b1;
         end
         srb_pkg::OFS_SPR_IDX: begin
            if (!req_wr_ff) rsp_data_in = 8'(cur_ff);
            cur_in = srb_pkg::SPR_W'(srb_pkg::mod_reduce(req_data_ff, srb_pkg::NUM_SPRITES));
         end
         [srb_pkg::OFS_COL_DET_FIRST:srb_pkg::OFS_COL_DET_LAST]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get32(col_det_ff[cur_ff], req_ofs_ff[1:0]);
            col_det_in = srb_pkg::put32(col_det_ff[cur_ff], req_ofs_ff[1:0], req_data_ff);
            col_det_we = 1'b1;
         end
         [srb_pkg::OFS_H_POS_HI:srb_pkg::OFS_H_POS_LO]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get16(h_pos_ff[cur_ff], req_ofs_ff[0]);
            h_pos_in = srb_pkg::put16(h_pos_ff[cur_ff], req_ofs_ff[0], req_data_ff);
            h_pos_we = 1'b1;
         end
         [srb_pkg::OFS_V_POS_HI:srb_pkg::OFS_V_POS_LO]: begin
            if (!req_wr_ff) rsp_data_in = srb_pkg::get16(v_pos_ff[cur_ff], req_ofs_ff[0]);
            v_pos_in = srb_pkg::put16(v_pos_ff[cur_ff], req_ofs_ff[0], req_data_ff);
            v_pos_we = 1'b1;
         end
         srb_pkg::OFS_X_OFS: begin
            if (!req_wr_ff) rsp_data_in = x_ofs_ff[cur_ff];
            x_ofs_we = 1'b1;
         end
         srb_pkg::OFS_Y_OFS: begin
            if (!req_wr_ff) rsp_data_in = y_ofs_ff[cur_ff];
            y_ofs_we = 1'b1;
         end
         srb_pkg::OFS_PRIO: begin
            if (!req_wr_ff) rsp_data_in = prio_ff[cur_ff];
            prio_we = 1'b1;
         end
         srb_pkg::OFS_BMP_IDX: begin
            if (!req_wr_ff) rsp_data_in = bmp_idx_ff[cur_ff];
            bmp_idx_we = 1'b1;
         end
         srb_pkg::OFS_BMP_DATA: begin
            if (!req_wr_ff) rsp_data_in = pix_rdata;
            pix_mod_we = 1'b1;
         end
         default: begin
            rsp_data_in = req_data_ff;
         end
      endcase
   end

   // Memory write ports: the clearing pass or an executing write.
   assign pal_clr_we  = cmd.clear && (int'(clr_cnt_ff) < srb_pkg::PALETTE_ENTRIES);
   assign pix_clr_we  = cmd.clear && (int'(clr_cnt_ff) < srb_pkg::PIX_DEPTH);
   assign pal_we      = pal_clr_we || (wr && pal_mod_we);
   assign pix_we      = pix_clr_we || (wr && pix_mod_we);
   assign pal_wr_addr = cmd.clear ? clr_cnt_ff[srb_pkg::PAL_W-1:0] : pal_addr;
   assign pix_wr_addr = cmd.clear ? clr_cnt_ff[srb_pkg::PIX_ADDR_W-1:0] : pix_addr;
   assign pal_wdata   = cmd.clear ? 16'd0 : pal_mod_data;
   assign pix_wdata   = cmd.clear ? 8'd0 : req_data_ff;

   srb_ram #(
      .WIDTH(16),
      .DEPTH(srb_pkg::PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(pal_wr_addr),
      .wr_data(pal_wdata),
      .rd_addr(pal_addr),
      .rd_data(pal_rdata)
   );

   srb_ram #(
      .WIDTH(8),
      .DEPTH(srb_pkg::PIX_DEPTH)
   ) u_pixel_ram (
      .clock  (clock),
      .wr_en  (pix_we),
      .wr_addr(pix_wr_addr),
      .wr_data(pix_wdata),
      .rd_addr(pix_addr),
      .rd_data(pix_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_wr_ff   <= req_type;
         req_ofs_ff  <= reg_offset;
         req_data_ff <= wr_data;
      end
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         enable_ff  <= '0;
         col_ena_ff <= '0;
         col_typ_ff <= '0;
         pal_ptr_ff <= '0;
         cur_ff     <= '0;
         col_det_ff <= '{default: '0};
         h_pos_ff   <= '{default: '0};
         v_pos_ff   <= '{default: '0};
         x_ofs_ff   <= '{default: '0};
         y_ofs_ff   <= '{default: '0};
         prio_ff    <= '{default: '0};
         bmp_idx_ff <= '{default: '0};
      end else begin
         if (cmd.clear) begin
            clr_cnt_ff <= srb_pkg::CLR_W'(clr_cnt_ff + 1'b1);
         end
         if (wr) begin
            enable_ff  <= enable_in;
            col_ena_ff <= col_ena_in;
            col_typ_ff <= col_typ_in;
            pal_ptr_ff <= pal_ptr_in;
            cur_ff     <= cur_in;
            if (col_det_we) col_det_ff[cur_ff] <= col_det_in;
            if (h_pos_we)   h_pos_ff[cur_ff]   <= h_pos_in;
            if (v_pos_we)   v_pos_ff[cur_ff]   <= v_pos_in;
            if (x_ofs_we)   x_ofs_ff[cur_ff]   <= byte_in;
            if (y_ofs_we)   y_ofs_ff[cur_ff]   <= byte_in;
            if (prio_we)    prio_ff[cur_ff]    <= byte_in;
            if (bmp_idx_we) bmp_idx_ff[cur_ff] <= byte_in;
         end
      end
   end

   assign rd_data = rsp_data_ff;

endmodule

@@ dv/tb_sprite_register_bank_core.sv @@
// ---------------------------------------------------------------------------
// Sprite register bank core testbench
// Drives byte read and write transactions into the bank, keeps a shadow copy
// of every register and memory, and checks each response byte in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_register_bank_core;

   typedef enum logic {
      ACC_READ  = 1'b0,
      ACC_WRITE = 1'b1
   } access_kind_type;

   typedef struct packed {
      access_kind_type kind;
      logic [4:0]      ofs;
      logic [7:0]      data;
   } bus_access_type;

   localparam logic [4:0] OFS_UNMAPPED_FIRST = 5'd29;
   localparam logic [4:0] OFS_UNMAPPED_LAST  = 5'd31;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_REPORTS   = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // reg_offset[4:0], wr_data[12:5], zero[15:13]
   logic [0:0]  req_tuser  = '0;   // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // rd_data[7:0]

   logic        hold_rsp   = 1'b0;

   bus_access_type pending_accesses[$];
   logic [7:0]     expected_rd_data[$];
   int             total_items    = 0;
   int             accepted_count = 0;
   int             error_count    = 0;

   // Shadow copy of the bank.
   logic [31:0] enable_word;
   logic [31:0] col_enable_word;
   logic [31:0] col_type_word;
   logic [7:0]  pal_index;
   logic [15:0] palette_mem [srb_pkg::PALETTE_ENTRIES];
   logic [4:0]  sprite_sel;
   logic [31:0] sprite_collide [srb_pkg::NUM_SPRITES];
   logic [15:0] sprite_hpos [srb_pkg::NUM_SPRITES];
   logic [15:0] sprite_vpos [srb_pkg::NUM_SPRITES];
   logic [7:0]  sprite_xofs [srb_pkg::NUM_SPRITES];
   logic [7:0]  sprite_yofs [srb_pkg::NUM_SPRITES];
   logic [7:0]  sprite_prio [srb_pkg::NUM_SPRITES];
   logic [7:0]  bmp_index [srb_pkg::NUM_SPRITES];
   logic [7:0]  bitmap_mem [srb_pkg::PIX_DEPTH];

   sprite_register_bank_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Lane 0 is the most significant byte of a word.
   function automatic logic [7:0] lane32(inout logic [31:0] w, input logic [1:0] lane,
                                         input logic wr, input logic [7:0] d);
      int sh;
      sh = (3 - int'(lane)) * 8;
      if (wr) begin
         w[sh +: 8] = d;
         return d;
      end
      return w[sh +: 8];
   endfunction

   function automatic logic [7:0] lane16(inout logic [15:0] w, input logic lane,
                                         input logic wr, input logic [7:0] d);
      int sh;
      sh = lane ? 0 : 8;
      if (wr) begin
         w[sh +: 8] = d;
         return d;
      end
      return w[sh +: 8];
   endfunction

   function automatic logic [7:0] sprite_bank_access(input access_kind_type kind,
                                                     input logic [4:0] ofs,
                                                     input logic [7:0] d);
      logic        wr;
      logic [7:0]  r;
      int unsigned pal;
      int unsigned pix;
      wr  = (kind == ACC_WRITE);
      r   = d;
      pal = int'(pal_index) % srb_pkg::PALETTE_ENTRIES;
      pix = int'(sprite_sel) * srb_pkg::PIXELS_PER_SPRITE
            + int'(bmp_index[sprite_sel]) % srb_pkg::PIXELS_PER_SPRITE;
      if (ofs <= srb_pkg::OFS_ENABLE_LAST) begin
         r = lane32(enable_word, 2'(ofs - srb_pkg::OFS_ENABLE_FIRST), wr, d);
      end else if (ofs <= srb_pkg::OFS_COL_ENA_LAST) begin
         r = lane32(col_enable_word, 2'(ofs - srb_pkg::OFS_COL_ENA_FIRST), wr, d);
      end else if (ofs <= srb_pkg::OFS_COL_TYP_LAST) begin
         r = lane32(col_type_word, 2'(ofs - srb_pkg::OFS_COL_TYP_FIRST), wr, d);
      end else if (ofs == srb_pkg::OFS_PAL_IDX) begin
         if (wr) pal_index = d;
         else r = pal_index;
      end else if (ofs <= srb_pkg::OFS_PAL_DATA_LO) begin
         r = lane16(palette_mem[pal], 1'(ofs - srb_pkg::OFS_PAL_DATA_HI), wr, d);
      end else if (ofs == srb_pkg::OFS_SPR_IDX) begin
         if (wr) sprite_sel = 5'(int'(d) % srb_pkg::NUM_SPRITES);
         else r = 8'(sprite_sel);
      end else if (ofs <= srb_pkg::OFS_COL_DET_LAST) begin
         r = lane32(sprite_collide[sprite_sel], 2'(ofs - srb_pkg::OFS_COL_DET_FIRST), wr, d);
      end else if (ofs <= srb_pkg::OFS_H_POS_LO) begin
         r = lane16(sprite_hpos[sprite_sel], 1'(ofs - srb_pkg::OFS_H_POS_HI), wr, d);
      end else if (ofs <= srb_pkg::OFS_V_POS_LO) begin
         r = lane16(sprite_vpos[sprite_sel], 1'(ofs - srb_pkg::OFS_V_POS_HI), wr, d);
      end else if (ofs == srb_pkg::OFS_X_OFS) begin
         if (wr) sprite_xofs[sprite_sel] = d;
         else r = sprite_xofs[sprite_sel];
      end else if (ofs == srb_pkg::OFS_Y_OFS) begin
         if (wr) sprite_yofs[sprite_sel] = d;
         else r = sprite_yofs[sprite_sel];
      end else if (ofs == srb_pkg::OFS_PRIO) begin
         if (wr) sprite_prio[sprite_sel] = d;
         else r = sprite_prio[sprite_sel];
      end else if (ofs == srb_pkg::OFS_BMP_IDX) begin
         if (wr) bmp_index[sprite_sel] = d;
         else r = bmp_index[sprite_sel];
      end else if (ofs == srb_pkg::OFS_BMP_DATA) begin
         if (wr) bitmap_mem[pix] = d;
         else r = bitmap_mem[pix];
      end
      return r;
   endfunction

   function automatic void queue_access(input access_kind_type kind, input logic [4:0] ofs,
                                        input logic [7:0] data);
      bus_access_type a;
      a.kind = kind;
      a.ofs  = ofs;
      a.data = data;
      pending_accesses = {pending_accesses, a};
   endfunction

   function automatic access_kind_type random_kind();
      return access_kind_type'($urandom_range(0, 1));
   endfunction

   // Mostly a small pool of pointer values so that written entries are read back.
   function automatic logic [7:0] pointer_value();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int traffic_phase();
      if (accepted_count < total_items / 3) return 0;
      if (accepted_count < (2 * total_items) / 3) return 1;
      return 2;
   endfunction

   function automatic int sender_idle_pct();
      case (traffic_phase())
         0:       return 38;
         1:       return 71;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (traffic_phase())
         0:       return 71;
         1:       return 38;
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin : req_driver
      bus_access_type next_access;
      logic [7:0]     predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = sprite_bank_access(access_kind_type'(req_tuser[0]),
                                           req_tdata[4:0], req_tdata[12:5]);
            expected_rd_data = {expected_rd_data, predicted};
            accepted_count++;
         end
         // A new transaction may be offered only once the current one is taken.
         if (!req_tvalid || req_tready) begin
            if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               next_access = pending_accesses.pop_front();
               req_tvalid  <= 1'b1;
               req_tuser   <= next_access.kind;
               req_tdata   <= {3'b000, next_access.data, next_access.ofs};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      logic [7:0] exp_byte;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rd_data.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected response: rd_data %02h", rsp_tdata);
            end else begin
               exp_byte = expected_rd_data.pop_front();
               if (rsp_tdata !== exp_byte) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("rd_data mismatch: expected %02h, actual %02h", exp_byte, rsp_tdata);
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // Back-pressure burst late in the run while the sender keeps offering.
   initial begin
      while (total_items == 0 || accepted_count < (5 * total_items) / 6) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int              mode;
      int              n;
      int              random_items;
      logic [4:0]      ofs;
      access_kind_type kind;

      enable_word     = '0;
      col_enable_word = '0;
      col_type_word   = '0;
      pal_index       = '0;
      sprite_sel      = '0;
      foreach (palette_mem[i]) palette_mem[i] = '0;
      foreach (bitmap_mem[i]) bitmap_mem[i] = '0;
      for (int s = 0; s < srb_pkg::NUM_SPRITES; s++) begin
         sprite_collide[s] = '0;
         sprite_hpos[s]    = '0;
         sprite_vpos[s]    = '0;
         sprite_xofs[s]    = '0;
         sprite_yofs[s]    = '0;
         sprite_prio[s]    = '0;
         bmp_index[s]      = '0;
      end

      // Directed: lane order of each flag word from its own base, pointer
      // readback, sprite index wrap, pixel pointer at its top, unmapped echo.
      queue_access(ACC_READ,  srb_pkg::OFS_ENABLE_FIRST,   8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_ENABLE_FIRST,   8'hFF);
      queue_access(ACC_WRITE, srb_pkg::OFS_ENABLE_LAST,    8'h01);
      queue_access(ACC_READ,  srb_pkg::OFS_ENABLE_FIRST,   8'h00);
      queue_access(ACC_READ,  srb_pkg::OFS_ENABLE_LAST,    8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_COL_ENA_FIRST,  8'hA5);
      queue_access(ACC_READ,  srb_pkg::OFS_COL_ENA_FIRST,  8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_COL_TYP_LAST,   8'h5A);
      queue_access(ACC_READ,  srb_pkg::OFS_COL_TYP_FIRST,  8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_PAL_IDX,        8'hFF);
      queue_access(ACC_READ,  srb_pkg::OFS_PAL_IDX,        8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_PAL_DATA_HI,    8'h80);
      queue_access(ACC_WRITE, srb_pkg::OFS_PAL_DATA_LO,    8'h7F);
      queue_access(ACC_READ,  srb_pkg::OFS_PAL_DATA_HI,    8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_SPR_IDX,        8'hFF);
      queue_access(ACC_READ,  srb_pkg::OFS_SPR_IDX,        8'h00);
      queue_access(ACC_WRITE, srb_pkg::OFS_COL_DET_FIRST,  8'hFF);
      queue_access(ACC_WRITE, srb_pkg::OFS_H_POS_LO,       8'h01);
      queue_access(ACC_WRITE, srb_pkg::OFS_BMP_IDX,        8'hFF);
      queue_access(ACC_WRITE, srb_pkg::OFS_BMP_DATA,       8'h3C);
      queue_access(ACC_READ,  srb_pkg::OFS_BMP_DATA,       8'h00);
      queue_access(ACC_WRITE, OFS_UNMAPPED_LAST,           8'hAA);
      queue_access(ACC_READ,  OFS_UNMAPPED_FIRST,          8'h55);
      queue_access(ACC_WRITE, srb_pkg::OFS_SPR_IDX,        8'h20);
      queue_access(ACC_READ,  srb_pkg::OFS_COL_DET_FIRST,  8'h00);

      // Random: mostly short sequences that select a sprite or palette entry and then
      // touch its registers, or that touch the flag words, with single stray transactions mixed in.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode <= 2) begin
            queue_access(random_kind(), 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
            random_items++;
         end else if (mode <= 5) begin
            queue_access(ACC_WRITE, srb_pkg::OFS_SPR_IDX,
                         8'($urandom_range(0, 3)
                            + srb_pkg::NUM_SPRITES * $urandom_range(0, 7)));
            n = $urandom_range(2, 6);
            for (int k = 0; k < n; k++) begin
               ofs  = 5'($urandom_range(int'(srb_pkg::OFS_COL_DET_FIRST),
                                        int'(srb_pkg::OFS_BMP_DATA)));
               kind = random_kind();
               if (ofs == srb_pkg::OFS_BMP_IDX && kind == ACC_WRITE)
                  queue_access(kind, ofs, pointer_value());
               else
                  queue_access(kind, ofs, 8'($urandom_range(0, 255)));
            end
            random_items += n + 1;
         end else if (mode <= 7) begin
            queue_access(ACC_WRITE, srb_pkg::OFS_PAL_IDX, pointer_value());
            n = $urandom_range(2, 5);
            for (int k = 0; k < n; k++) begin
               ofs = 5'($urandom_range(int'(srb_pkg::OFS_PAL_IDX),
                                       int'(srb_pkg::OFS_PAL_DATA_LO)));
               if (ofs == srb_pkg::OFS_PAL_IDX)
                  queue_access(ACC_READ, ofs, 8'($urandom_range(0, 255)));
               else
                  queue_access(random_kind(), ofs, 8'($urandom_range(0, 255)));
            end
            random_items += n + 1;
         end else begin
            n = $urandom_range(2, 5);
            for (int k = 0; k < n; k++)
               queue_access(random_kind(),
                            5'($urandom_range(int'(srb_pkg::OFS_ENABLE_FIRST),
                                              int'(srb_pkg::OFS_COL_TYP_LAST))),
                            8'($urandom_range(0, 255)));
            random_items += n;
         end
      end
      total_items = pending_accesses.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (expected_rd_data.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += expected_rd_data.size();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
